// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks used by the top-level RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/lccp_pkg.sv
// ----------------------------------------------------------------------------
// lccp_pkg
// Shared types and constants of the coefficient compress and pack block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lccp_pkg;

  // width_select codes
  localparam logic [2:0] SEL_1BIT  = 3'd0;
  localparam logic [2:0] SEL_4BIT  = 3'd1;
  localparam logic [2:0] SEL_5BIT  = 3'd2;
  localparam logic [2:0] SEL_10BIT = 3'd3;
  localparam logic [2:0] SEL_11BIT = 3'd4;
  localparam logic [2:0] SEL_PACK  = 3'd5;

  localparam logic [2:0] SEL_RESET = SEL_4BIT;

  // register index of width_select
  localparam logic REG_WIDTH_SELECT = 1'b0;

  localparam int OPA_W  = 27;
  localparam int OPB_W  = 21;
  localparam int PROD_W = OPA_W + OPB_W;

  localparam logic [OPB_W-1:0] MUL_1_4 = 21'd80635;
  localparam logic [OPB_W-1:0] MUL_5   = 21'd40318;
  localparam logic [OPB_W-1:0] MUL_10  = 21'd1290167;
  localparam logic [OPB_W-1:0] MUL_11  = 21'd645084;
  localparam logic [OPB_W-1:0] MUL_ONE = 21'd1;

  localparam logic [OPA_W-1:0] RND_HI = 27'd1665;
  localparam logic [OPA_W-1:0] RND_LO = 27'd1664;

  localparam logic [15:0] Q_MODULUS = 16'd3329;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [11:0] code;
    logic [3:0]  nbits;
    logic        last;
  } lccp_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lccp_qstat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } lccp_byte_t;

endpackage

// File: rtl/lccp_front.sv
// ----------------------------------------------------------------------------
// lccp_front
// Accepts coefficients, selects the multiplier operands for the mode,
// multiplies and extracts the compressed code with its bit count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lccp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          width_select,
  input  logic [15:0]         coefficient,
  input  logic                last_coefficient,
  input  logic                in_valid,
  output logic                in_ready,
  input  lccp_pkg::lccp_qstat_t qstat,
  output logic                push,
  output lccp_pkg::lccp_item_t  item
);

  logic                       en;
  logic [lccp_pkg::OPA_W-1:0] opa;
  logic [lccp_pkg::OPB_W-1:0] opb;
  logic [2:0]                 sel;
  logic [3:0]                 nbits;
  logic [15:0]                xp;

  logic                        v1;
  logic [lccp_pkg::OPA_W-1:0]  a1;
  logic [lccp_pkg::OPB_W-1:0]  b1;
  logic [2:0]                  sel1;
  logic [3:0]                  nb1;
  logic                        last1;

  logic                        v2;
  logic [lccp_pkg::PROD_W-1:0] prod2;
  logic [2:0]                  sel2;
  logic [3:0]                  nb2;
  logic                        last2;

  // the whole pipeline freezes while the queue is full
  assign en       = !qstat.full;
  assign in_ready = en;

  assign xp = coefficient[15] ? coefficient + lccp_pkg::Q_MODULUS : coefficient;

  always_comb begin
    unique case (width_select)
      lccp_pkg::SEL_1BIT: begin
        opa   = {10'b0, coefficient, 1'b0} + lccp_pkg::RND_HI;
        opb   = lccp_pkg::MUL_1_4;
        sel   = lccp_pkg::SEL_1BIT;
        nbits = 4'd1;
      end
      lccp_pkg::SEL_4BIT: begin
        opa   = {7'b0, coefficient, 4'b0} + lccp_pkg::RND_HI;
        opb   = lccp_pkg::MUL_1_4;
        sel   = lccp_pkg::SEL_4BIT;
        nbits = 4'd4;
      end
      lccp_pkg::SEL_5BIT: begin
        opa   = {6'b0, coefficient, 5'b0} + lccp_pkg::RND_LO;
        opb   = lccp_pkg::MUL_5;
        sel   = lccp_pkg::SEL_5BIT;
        nbits = 4'd5;
      end
      lccp_pkg::SEL_10BIT: begin
        opa   = {1'b0, coefficient, 10'b0} + lccp_pkg::RND_HI;
        opb   = lccp_pkg::MUL_10;
        sel   = lccp_pkg::SEL_10BIT;
        nbits = 4'd10;
      end
      lccp_pkg::SEL_11BIT: begin
        opa   = {coefficient, 11'b0} + lccp_pkg::RND_LO;
        opb   = lccp_pkg::MUL_11;
        sel   = lccp_pkg::SEL_11BIT;
        nbits = 4'd11;
      end
      default: begin
        // pack mode and unused codes: pass the 12-bit value through the multiplier
        opa   = {15'b0, xp[11:0]};
        opb   = lccp_pkg::MUL_ONE;
        sel   = lccp_pkg::SEL_PACK;
        nbits = 4'd12;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1    <= opa;
      b1    <= opb;
      sel1  <= sel;
      nb1   <= nbits;
      last1 <= last_coefficient;
      prod2 <= {{lccp_pkg::OPB_W{1'b0}}, a1} * {{lccp_pkg::OPA_W{1'b0}}, b1};
      sel2  <= sel1;
      nb2   <= nb1;
      last2 <= last1;
    end
  end

  assign push = v2 && en;

  // low 32 product bits give the wrapped result of the narrow modes
  always_comb begin
    item.nbits = nb2;
    item.last  = last2;
    unique case (sel2)
      lccp_pkg::SEL_1BIT:  item.code = {11'b0, prod2[28]};
      lccp_pkg::SEL_4BIT:  item.code = {8'b0, prod2[31:28]};
      lccp_pkg::SEL_5BIT:  item.code = {7'b0, prod2[31:27]};
      lccp_pkg::SEL_10BIT: item.code = {2'b0, prod2[41:32]};
      lccp_pkg::SEL_11BIT: item.code = {1'b0, prod2[41:31]};
      default:             item.code = prod2[11:0];
    endcase
  end

endmodule

// File: rtl/lccp_queue.sv
// ----------------------------------------------------------------------------
// lccp_queue
// Short FIFO of coded coefficients between the front and the packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lccp_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lccp_pkg::lccp_item_t  wr_item,
  input  logic                  pop,
  output lccp_pkg::lccp_item_t  rd_item,
  output lccp_pkg::lccp_qstat_t qstat
);

  lccp_pkg::lccp_item_t         mem [lccp_pkg::QDEPTH];
  logic [lccp_pkg::QPTR_W-1:0]  wr_ptr;
  logic [lccp_pkg::QPTR_W-1:0]  rd_ptr;
  logic [lccp_pkg::QCNT_W-1:0]  count;
  logic [lccp_pkg::QCNT_W-1:0]  count_next;

  assign qstat.full  = (count == lccp_pkg::QCNT_W'(lccp_pkg::QDEPTH));
  assign qstat.empty = (count == '0);
  assign rd_item     = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

// File: rtl/lccp_back.sv
// ----------------------------------------------------------------------------
// lccp_back
// Appends codes LSB-first to the bit buffer and drives out finished bytes
// through a two-entry output buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lccp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  lccp_pkg::lccp_item_t  item,
  input  lccp_pkg::lccp_qstat_t qstat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lccp_pkg::lccp_byte_t  out_beat
);

  logic [6:0]  pending_bits;
  logic [2:0]  pending_count;
  logic [18:0] acc;
  logic [4:0]  total;
  logic [4:0]  rem_total;
  logic [18:0] rem_acc;
  logic [1:0]  n_new;
  lccp_pkg::lccp_byte_t new0;
  lccp_pkg::lccp_byte_t new1;

  lccp_pkg::lccp_byte_t ob0;
  lccp_pkg::lccp_byte_t ob1;
  logic [1:0]           ocnt;

  assign out_valid = (ocnt != 2'd0);
  assign out_beat  = ob0;

  // take an item only when the output buffer is empty after this cycle
  assign pop = !qstat.empty && ((ocnt == 2'd0) || ((ocnt == 2'd1) && out_ready));

  assign acc   = {12'b0, pending_bits} | ({7'b0, item.code} << pending_count);
  assign total = {2'b0, pending_count} + {1'b0, item.nbits};

  always_comb begin
    new0.data = acc[7:0];
    new0.last = 1'b0;
    new1.data = acc[15:8];
    new1.last = 1'b0;
    if (total >= 5'd16) begin
      n_new     = 2'd2;
      rem_acc   = acc >> 16;
      rem_total = total - 5'd16;
    end else if (total >= 5'd8) begin
      n_new     = 2'd1;
      rem_acc   = acc >> 8;
      rem_total = total - 5'd8;
    end else begin
      n_new     = 2'd0;
      rem_acc   = acc;
      rem_total = total;
    end
    if (item.last) begin
      // flush leftover bits as a zero-padded byte if a slot is free, else drop
      case (n_new)
        2'd0: begin
          n_new     = 2'd1;
          new0.last = 1'b1;
        end
        2'd1: begin
          if (rem_total != 5'd0) begin
            n_new     = 2'd2;
            new1.last = 1'b1;
          end else begin
            new0.last = 1'b1;
          end
        end
        default: begin
          new1.last = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
      ocnt          <= '0;
    end else begin
      if (pop) begin
        if (item.last) begin
          pending_bits  <= '0;
          pending_count <= '0;
        end else begin
          pending_bits  <= rem_acc[6:0];
          pending_count <= rem_total[2:0];
        end
        ocnt <= n_new;
      end else if (out_valid && out_ready) begin
        ocnt <= ocnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ob0 <= new0;
      ob1 <= new1;
    end else if (out_valid && out_ready) begin
      ob0 <= ob1;
    end
  end

endmodule

// File: rtl/lattice_coeff_compress_pack.sv
// ----------------------------------------------------------------------------
// lattice_coeff_compress_pack
// Coefficient compressor and LSB-first byte packer with APB width register.
// ----------------------------------------------------------------------------
// The block accepts one 16-bit coefficient per clock while its queue has
// room; an operand-select stage and a multiply stage (one 27x21 product)
// put the compressed code into a four-entry queue, and the packer turns
// it into bytes. The output port delivers one byte per cycle while m_tready
// is high, so a coefficient that completes two bytes holds the packer back,
// and the sustained input rate is one coefficient per cycle while m_tready
// stays high and the modes average at most eight bits per coefficient.
// The user must write width_select only while no coefficient is in flight,
// which the block does not enforce; codes 6 and 7 act as 12-bit pack mode.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lattice_coeff_compress_pack (
  input  logic               clk,
  input  logic               rst,
  // APB configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input stream
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic signed [15:0] s_tdata,   // [15:0] coefficient
  input  logic               s_tlast,   // last_coefficient
  // output stream
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,   // [7:0] out_byte
  output logic               m_tlast    // last_byte
);

  logic [2:0]            width_select;
  logic                  cfg_write;
  logic                  q_push;
  logic                  q_pop;
  lccp_pkg::lccp_item_t  wr_item;
  lccp_pkg::lccp_item_t  rd_item;
  lccp_pkg::lccp_qstat_t qstat;
  lccp_pkg::lccp_byte_t  out_beat;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[2] == lccp_pkg::REG_WIDTH_SELECT);
  assign prdata    = (paddr[2] == lccp_pkg::REG_WIDTH_SELECT) ? {29'b0, width_select} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_select <= lccp_pkg::SEL_RESET;
    end else if (cfg_write) begin
      width_select <= pwdata[2:0];
    end
  end

  lccp_front u_front (
    .clk              (clk),
    .rst              (rst),
    .width_select     (width_select),
    .coefficient      (s_tdata[15:0]),
    .last_coefficient (s_tlast),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .qstat            (qstat),
    .push             (q_push),
    .item             (wr_item)
  );

  lccp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (wr_item),
    .pop     (q_pop),
    .rd_item (rd_item),
    .qstat   (qstat)
  );

  lccp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .item      (rd_item),
    .qstat     (qstat),
    .pop       (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_beat  (out_beat)
  );

  assign m_tdata = out_beat.data;
  assign m_tlast = out_beat.last;

  `ASSERT_NEXT(a_cfg_write, cfg_write, width_select == $past(pwdata[2:0]))
  `ASSERT_NOW(a_no_overflow, q_push, !qstat.full)
  `ASSERT_NOW(a_no_underflow, q_pop, !qstat.empty)
  `ASSERT_NOW(a_stall_when_full, qstat.full, !s_tready)

endmodule
